FILE: hdl/utrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrd_pkg
// shared types, sizes and helpers for the radix digit converter
// ----------------------------------------------------------------------------
package utrd_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int MAX_DIGITS  = 64;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
	localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

	localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);
	localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0]  CHAR_A     = CHAR_W'(8'h41);

	// link between neighboring cells: token valid plus carry bit
	typedef struct packed {
		logic vld;
		logic carry;
	} link_t;

	function automatic logic radix_ok(input logic [RADIX_W-1:0] r);
		radix_ok = (r >= RADIX_MIN) && (r <= RADIX_MAX);
	endfunction

	function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
		if (d < DEC_DIGITS)
			digit_to_char = CHAR_ZERO + CHAR_W'(d);
		else
			digit_to_char = CHAR_A + CHAR_W'(d - DEC_DIGITS);
	endfunction

endpackage

FILE: hdl/unsigned_to_radix_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits
// unsigned integer to ascii digit string in radix 2 to 36
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The value is fed
// msb first into a row of MAX_DIGITS digit cells; each cell doubles its digit,
// adds the carry from its lower neighbor and reduces mod radix. Carries pass
// through a register between cells, so the bits travel the row as a skewed
// wave. The row then shifts toward the top cell, first dropping leading
// zeros, then putting out one digit per cycle most significant first, with a
// step without a shift where the sequencer turns from dropping to sending.
// The last result shows in the first cycle with busy low, and the next
// request can be taken at the edge ending that cycle. Each result is shown
// for one cycle with result_valid high and the receiver cannot stall it;
// last_digit marks the units digit. A radix outside 2 to 36 gives a single
// result with error set in the cycle after the request, and busy stays low.
// If the value has more than MAX_DIGITS digits only the low MAX_DIGITS are
// sent, leading zeros included. radix is written through radix_we /
// radix_wdata; the user must write it only while busy is low, as the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits import utrd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               radix_we,
	input  logic [RADIX_W-1:0] radix_wdata,
	input  logic               start,
	output logic               busy,
	input  logic [63:0]        value,
	output logic               result_valid,
	output logic [CHAR_W-1:0]  digit_char,
	output logic               last_digit,
	output logic               error
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + MAX_DIGITS);
	localparam int REM_W = $clog2(MAX_DIGITS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SKIP = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]             state_q;
	logic [RADIX_W-1:0]     radix_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [REM_W-1:0]       rem_q;
	logic                   ovf_q;

	logic                   valid_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   err_q;

	// chain wiring: link_w[i] feeds cell i, link_w[MAX_DIGITS] leaves the top
	link_t                  link_w  [MAX_DIGITS+1];
	logic [DIGIT_W-1:0]     digit_w [MAX_DIGITS];

	logic                   accept;
	logic                   clear;
	logic                   shift;
	logic                   skip_more;
	logic [DIGIT_W-1:0]     top_digit;

	assign accept    = start & ~busy;
	assign clear     = accept;
	assign top_digit = digit_w[MAX_DIGITS-1];
	// drop a leading zero unless it is the only digit left or the value overflowed
	assign skip_more = (top_digit == '0) && (rem_q > REM_W'(1)) && !ovf_q;
	assign shift     = (state_q == ST_EMIT) || ((state_q == ST_SKIP) && skip_more);

	// feed bits msb first while the input window is open
	assign link_w[0].vld   = (state_q == ST_CONV) && (cnt_q < CNT_W'(VALUE_WIDTH));
	assign link_w[0].carry = val_q[VALUE_WIDTH-1];

	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
		utrd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (clear),
			.shift    (shift),
			.radix    (radix_q),
			.link_in  (link_w[i]),
			.digit_in ((i == 0) ? DIGIT_W'(0) : digit_w[(i == 0) ? 0 : i-1]),
			.link_out (link_w[i+1]),
			.digit    (digit_w[i])
		);
	end

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= RADIX_RESET;
		else if (radix_we)
			radix_q <= radix_wdata;
	end

	// value shift register, no reset needed
	always_ff @(posedge clk) begin
		if (accept)
			val_q <= value[VALUE_WIDTH-1:0];
		else if (state_q == ST_CONV)
			val_q <= {val_q[VALUE_WIDTH-2:0], 1'b0};
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= '0;
			ovf_q   <= 1'b0;
			valid_q <= 1'b0;
			char_q  <= '0;
			last_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (radix_ok(radix_q)) begin
							state_q <= ST_CONV;
							cnt_q   <= '0;
							rem_q   <= REM_W'(MAX_DIGITS);
							ovf_q   <= 1'b0;
						end else begin
							// bad radix: one error result
							valid_q <= 1'b1;
							char_q  <= '0;
							last_q  <= 1'b1;
							err_q   <= 1'b1;
						end
					end
				end
				ST_CONV: begin
					// carry out of the top cell means more digits than cells
					if (link_w[MAX_DIGITS].vld && link_w[MAX_DIGITS].carry)
						ovf_q <= 1'b1;
					cnt_q <= cnt_q + CNT_W'(1);
					// the last count value lets the top carry register land
					if (cnt_q == CNT_W'(VALUE_WIDTH + MAX_DIGITS - 1))
						state_q <= ST_SKIP;
				end
				ST_SKIP: begin
					if (skip_more)
						rem_q <= rem_q - REM_W'(1);
					else
						state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					valid_q <= 1'b1;
					char_q  <= digit_to_char(top_digit);
					last_q  <= (rem_q == REM_W'(1));
					err_q   <= 1'b0;
					rem_q   <= rem_q - REM_W'(1);
					if (rem_q == REM_W'(1))
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = valid_q;
	assign digit_char   = char_q;
	assign last_digit   = last_q;
	assign error        = err_q;

endmodule

FILE: hdl/utrd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utrd_cell
// one digit cell: doubles its digit and adds the carry, reduced mod radix
// ----------------------------------------------------------------------------
module utrd_cell import utrd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               clear,
	input  logic               shift,
	input  logic [RADIX_W-1:0] radix,
	input  link_t              link_in,
	input  logic [DIGIT_W-1:0] digit_in,
	output link_t              link_out,
	output logic [DIGIT_W-1:0] digit
);

	logic [DIGIT_W-1:0] digit_q;
	link_t              link_q;
	logic [DIGIT_W:0]   sum;
	logic               ge;
	logic [DIGIT_W-1:0] nxt;

	assign sum = {digit_q, link_in.carry};
	assign ge  = sum >= {1'b0, radix};
	assign nxt = ge ? DIGIT_W'(sum - {1'b0, radix}) : DIGIT_W'(sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
			link_q  <= '0;
		end else if (clear) begin
			digit_q <= '0;
			link_q  <= '0;
		end else begin
			link_q.vld   <= link_in.vld;
			link_q.carry <= link_in.vld & ge;
			if (shift)
				digit_q <= digit_in;
			else if (link_in.vld)
				digit_q <= nxt;
		end
	end

	assign link_out = link_q;
	assign digit    = digit_q;

endmodule
